/* design/ebq_pkg.sv */
`timescale 1ns / 1ps

package ebq_pkg;

    // Default time width (event stamps and stored change times)
    localparam int TIME_WIDTH_DEF = 32;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] GLITCH_RESET  = CFG_DATA_W'(144000);
    localparam logic [CFG_DATA_W-1:0] LOCKOUT_RESET = CFG_DATA_W'(2400000);

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        CODE_CW     = 2'd0,
        CODE_CCW    = 2'd1,
        CODE_MODE   = 2'd2,
        CODE_SELECT = 2'd3
    } t_ebq_code;

    // One queued job: which messages this event produced, and the rotation direction
    typedef struct packed {
        logic sel;
        logic mode;
        logic rot;
        logic ccw;
    } t_ebq_job;

endpackage

/* design/ebq_if.sv */
`timescale 1ns / 1ps

interface ebq_evt_if #(
    parameter int TIME_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [TIME_WIDTH-1:0] event_tick;
    logic                  enca_edge;
    logic                  encb_edge;
    logic                  mode_edge;
    logic                  select_edge;
    logic                  enca_level;
    logic                  encb_level;

    modport source (
        output valid, event_tick, enca_edge, encb_edge, mode_edge, select_edge,
               enca_level, encb_level,
        input  ready
    );
    modport sink (
        input  valid, event_tick, enca_edge, encb_edge, mode_edge, select_edge,
               enca_level, encb_level,
        output ready
    );
endinterface

interface ebq_msg_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;
    logic       last_of_run;

    modport source (output valid, event_code, last_of_run, input ready);
    modport sink   (input valid, event_code, last_of_run, output ready);
endinterface

/* design/encoder_button_event_qualifier.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// i_evt     in   valid/ready        event_tick, enca/encb/mode/select_edge,
//                                   enca_level, encb_level
// o_msg     out  valid/ready        event_code, last_of_run
// i_cfg_*   in   write enable only  i_cfg_idx (0 glitch, 1 lockout), i_cfg_data
//
// Front stage qualifies one event per cycle while the job queue is not full:
// all time checks are single adds and compares against the stored change
// times, updated at accept. Events that produce messages go into a
// QUEUE_DEPTH-entry job queue; those that produce none are absorbed at accept.
// Back stage emits one message per cycle from the output register while
// o_msg.ready is high; i_evt.ready drops only while the job queue is full.
// Synchronous active-low reset loads default limits, clears times and pointers.

module encoder_button_event_qualifier import ebq_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ebq_evt_if.sink               i_evt,
    ebq_msg_if.source             o_msg
);

    // front -> queue
    logic     push;
    t_ebq_job push_job;
    logic     q_full;

    // queue -> back
    logic     pop;
    t_ebq_job head_job;
    logic     q_empty;

    ebq_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_evt      (i_evt),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // decouples event intake from message delivery
    ebq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // serializes rotation, mode, select in that order
    ebq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (head_job),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_msg     (o_msg)
    );

endmodule

/* design/ebq_front.sv */
`timescale 1ns / 1ps

module ebq_front import ebq_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ebq_evt_if.sink               i_evt,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_ebq_job              o_job
);

    logic [CFG_DATA_W-1:0] r_glitch;
    logic [CFG_DATA_W-1:0] r_lockout;

    logic [TIME_WIDTH-1:0] r_a_time;
    logic [TIME_WIDTH-1:0] r_b_time;
    logic [TIME_WIDTH-1:0] r_mode_time;
    logic [TIME_WIDTH-1:0] r_sel_time;
    logic                  r_b_latch;

    logic [TIME_WIDTH-1:0] glitch_t;
    logic [TIME_WIDTH-1:0] lockout_t;
    logic [TIME_WIDTH-1:0] now;
    logic                  accept;
    logic                  a_ok;
    logic                  mode_ok;
    logic                  sel_ok;

    assign glitch_t  = TIME_WIDTH'(r_glitch);
    assign lockout_t = TIME_WIDTH'(r_lockout);
    assign now       = i_evt.event_tick;

    assign i_evt.ready = !i_q_full;
    assign accept      = i_evt.valid && !i_q_full;

    // wrapped "last + limit <= now", or B moved after A's last change
    assign a_ok    = ((r_a_time + glitch_t) <= now) || (r_a_time < r_b_time);
    assign mode_ok = (r_mode_time + lockout_t) <= now;
    assign sel_ok  = (r_sel_time + lockout_t) <= now;

    always_comb begin
        o_job.rot  = i_evt.enca_edge && i_evt.enca_level && a_ok;
        o_job.ccw  = !r_b_latch;
        o_job.mode = i_evt.mode_edge && mode_ok;
        o_job.sel  = i_evt.select_edge && sel_ok;
        o_push     = accept && (o_job.rot || o_job.mode || o_job.sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glitch  <= GLITCH_RESET;
            r_lockout <= LOCKOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GLITCH:  r_glitch  <= i_cfg_data;
                CFG_LOCKOUT: r_lockout <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_time    <= '0;
            r_b_time    <= '0;
            r_mode_time <= '0;
            r_sel_time  <= '0;
            r_b_latch   <= 1'b0;
        end else if (accept) begin
            if (i_evt.enca_edge) begin
                r_a_time <= now;
                if (!i_evt.enca_level) begin
                    r_b_latch <= i_evt.encb_level;
                end
            end
            if (i_evt.encb_edge) begin
                r_b_time <= now;
            end
            if (i_evt.mode_edge) begin
                r_mode_time <= now;
            end
            if (i_evt.select_edge) begin
                r_sel_time <= now;
            end
        end
    end

endmodule

/* design/ebq_queue.sv */
`timescale 1ns / 1ps

module ebq_queue import ebq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_ebq_job i_job,
    input  logic     i_pop,
    output t_ebq_job o_job,
    output logic     o_empty,
    output logic     o_full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_ebq_job         r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (do_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: ;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_empty_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_job.rot || i_job.mode || i_job.sel))
        else $error("job with no message queued");

endmodule

/* design/ebq_back.sv */
`timescale 1ns / 1ps

module ebq_back import ebq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ebq_job i_job,
    input  logic     i_q_empty,
    output logic     o_pop,
    ebq_msg_if.source o_msg
);

    // pending messages of the job in hand: bit 0 rotation, 1 mode, 2 select
    logic [2:0] r_pend;
    logic       r_ccw;

    logic [2:0] rest;
    logic       sent;
    logic       take;
    t_ebq_code  code;

    assign rest = r_pend & (r_pend - 3'd1);
    assign sent = o_msg.valid && o_msg.ready;
    assign take = (r_pend == 3'd0) || (sent && rest == 3'd0);
    assign o_pop = take && !i_q_empty;

    always_comb begin
        if (r_pend[0]) begin
            code = r_ccw ? CODE_CCW : CODE_CW;
        end else if (r_pend[1]) begin
            code = CODE_MODE;
        end else begin
            code = CODE_SELECT;
        end
    end

    assign o_msg.valid       = (r_pend != 3'd0);
    assign o_msg.event_code  = code;
    assign o_msg.last_of_run = (rest == 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'd0;
        end else if (take) begin
            r_pend <= o_pop ? {i_job.sel, i_job.mode, i_job.rot} : 3'd0;
        end else if (sent) begin
            r_pend <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ccw <= i_job.ccw;
        end
    end

    a_last_one_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_msg.valid && o_msg.last_of_run) |-> ($countones(r_pend) == 1))
        else $error("last flag with more messages pending");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sent && !o_msg.last_of_run) |=> o_msg.valid)
        else $error("run cut short");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_msg.valid && !o_msg.ready) |=> $stable(r_pend))
        else $error("pending set changed while stalled");

endmodule

/* dv/tb_encoder_button_event_qualifier.sv */
`timescale 1ns / 1ps

module tb_encoder_button_event_qualifier;
    import ebq_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake on either side
    localparam int LONG_HOLD      = 400;   // receiver hold-off used to fill the job queue
    localparam int SETTLE_CYCLES  = 6;     // front stage absorbs silent events at once

    // One pin-change event request as the sender holds it
    typedef struct packed {
        logic [TIME_WIDTH_DEF-1:0] tick;
        logic                      a_edge;
        logic                      b_edge;
        logic                      mode_edge;
        logic                      sel_edge;
        logic                      a_level;
        logic                      b_level;
    } evt_item_t;

    // One message the block is expected to emit
    typedef struct {
        t_ebq_code code;
        logic      tail;
    } msg_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_GLITCH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ebq_evt_if #(.TIME_WIDTH(TIME_WIDTH_DEF)) evt ();
    ebq_msg_if                                msg ();

    encoder_button_event_qualifier #(
        .TIME_WIDTH (TIME_WIDTH_DEF)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_evt      (evt),
        .o_msg      (msg)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stimulus queue (filled by the sequencer) and expected messages (filled on accept)
    evt_item_t pending_events[$];
    msg_item_t expected_msgs[$];

    int unsigned err_cnt   = 0;
    bit          jitter_on = 1'b0;   // random gaps/stalls on both sides
    bit          hold_arm  = 1'b0;   // request for one long receiver hold-off
    bit          hold_done = 1'b0;
    logic [TIME_WIDTH_DEF-1:0] tick_now = '0;

    // Mostly short gaps, now and then a long one, half the time none
    function automatic int pick_gap();
        if ($urandom_range(0, 1) == 0)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------
    // Predictor: own copy of the qualifier state and both registers
    // ------------------------------------------------------------------
    logic [TIME_WIDTH_DEF-1:0] glitch_ticks;
    logic [TIME_WIDTH_DEF-1:0] lockout_ticks;
    logic [TIME_WIDTH_DEF-1:0] enc_a_stamp;
    logic [TIME_WIDTH_DEF-1:0] enc_b_stamp;
    logic [TIME_WIDTH_DEF-1:0] mode_stamp;
    logic [TIME_WIDTH_DEF-1:0] sel_stamp;
    logic                      b_latched;

    // Wrapped sum, unsigned compare: matches the tick counter rolling over
    function automatic logic tick_elapsed(input logic [TIME_WIDTH_DEF-1:0] last_stamp,
                                          input logic [TIME_WIDTH_DEF-1:0] limit,
                                          input logic [TIME_WIDTH_DEF-1:0] now);
        logic [TIME_WIDTH_DEF-1:0] due;
        due = last_stamp + limit;
        return due <= now;
    endfunction

    task automatic qualify_event(input evt_item_t it);
        t_ebq_code codes[$];
        msg_item_t m;
        if (it.a_edge) begin
            if (it.a_level) begin
                // rising A: rotation if quiet long enough or B moved since last A change
                if (tick_elapsed(enc_a_stamp, glitch_ticks, it.tick) ||
                    enc_a_stamp < enc_b_stamp)
                    codes.push_back(b_latched ? CODE_CW : CODE_CCW);
            end else begin
                b_latched = it.b_level;
            end
            enc_a_stamp = it.tick;
        end
        // B stamp updated after the A test (simultaneous flags use the old one)
        if (it.b_edge)
            enc_b_stamp = it.tick;
        if (it.mode_edge) begin
            if (tick_elapsed(mode_stamp, lockout_ticks, it.tick))
                codes.push_back(CODE_MODE);
            mode_stamp = it.tick;
        end
        if (it.sel_edge) begin
            if (tick_elapsed(sel_stamp, lockout_ticks, it.tick))
                codes.push_back(CODE_SELECT);
            sel_stamp = it.tick;
        end
        foreach (codes[i]) begin
            m.code = codes[i];
            m.tail = (i == codes.size() - 1);
            expected_msgs.push_back(m);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: register writes, accepted requests, accepted messages
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        evt_item_t seen;
        msg_item_t want;
        if (!rst_n) begin
            glitch_ticks  = GLITCH_RESET;
            lockout_ticks = LOCKOUT_RESET;
            enc_a_stamp   = '0;
            enc_b_stamp   = '0;
            mode_stamp    = '0;
            sel_stamp     = '0;
            b_latched     = 1'b0;
            expected_msgs.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_GLITCH:  glitch_ticks  = cfg_data;
                    CFG_LOCKOUT: lockout_ticks = cfg_data;
                    default: ;
                endcase
            end
            if (evt.valid && evt.ready) begin
                seen.tick      = evt.event_tick;
                seen.a_edge    = evt.enca_edge;
                seen.b_edge    = evt.encb_edge;
                seen.mode_edge = evt.mode_edge;
                seen.sel_edge  = evt.select_edge;
                seen.a_level   = evt.enca_level;
                seen.b_level   = evt.encb_level;
                qualify_event(seen);
            end
            if (msg.valid && msg.ready) begin
                if (expected_msgs.size() == 0) begin
                    $error("unexpected message: event_code %0d last_of_run %0d",
                           msg.event_code, msg.last_of_run);
                    err_cnt++;
                end else begin
                    want = expected_msgs.pop_front();
                    if (msg.event_code !== want.code) begin
                        $error("event_code mismatch: expected %0d, actual %0d",
                               want.code, msg.event_code);
                        err_cnt++;
                    end
                    if (msg.last_of_run !== want.tail) begin
                        $error("last_of_run mismatch: expected %0d, actual %0d",
                               want.tail, msg.last_of_run);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: one request held until accepted, gap drawn after each pop
    // ------------------------------------------------------------------
    evt_item_t drv_item = '0;
    bit        drv_busy = 1'b0;
    int        drv_gap  = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            drv_busy = 1'b0;
            drv_gap  = 0;
            evt.valid <= 1'b0;
        end else begin
            if (evt.valid && evt.ready)
                drv_busy = 1'b0;
            if (!drv_busy) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pending_events.size() > 0) begin
                    drv_item = pending_events.pop_front();
                    drv_busy = 1'b1;
                    drv_gap  = jitter_on ? pick_gap() : 0;
                end
            end
            // valid stays high across back-to-back requests: one assignment per edge
            evt.valid       <= drv_busy;
            evt.event_tick  <= drv_item.tick;
            evt.enca_edge   <= drv_item.a_edge;
            evt.encb_edge   <= drv_item.b_edge;
            evt.mode_edge   <= drv_item.mode_edge;
            evt.select_edge <= drv_item.sel_edge;
            evt.enca_level  <= drv_item.a_level;
            evt.encb_level  <= drv_item.b_level;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off to back up the queue
    // ------------------------------------------------------------------
    int rx_stall = 0;
    int rx_hold  = 0;

    always @(posedge clk) begin
        logic rdy;
        if (!rst_n) begin
            rx_stall = 0;
            rx_hold  = 0;
            msg.ready <= 1'b0;
        end else begin
            if (hold_arm && !hold_done) begin
                rx_hold   = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                rdy = 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if (jitter_on && $urandom_range(0, 3) == 0)
                    rx_stall = pick_gap();
            end
            msg.ready <= rdy;
        end
    end

    // Watchdog: too long with no handshake anywhere means a hang
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (evt.valid && evt.ready) || (msg.valid && msg.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** encoder_button_event_qualifier: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------
    task automatic push_at(input logic [TIME_WIDTH_DEF-1:0] tick,
                           input bit a_e, input bit b_e, input bit m_e, input bit s_e,
                           input bit a_l, input bit b_l);
        evt_item_t it;
        it.tick      = tick;
        it.a_edge    = a_e;
        it.b_edge    = b_e;
        it.mode_edge = m_e;
        it.sel_edge  = s_e;
        it.a_level   = a_l;
        it.b_level   = b_l;
        pending_events.push_back(it);
    endtask

    // Ticks mostly creep forward around the thresholds; now and then jump anywhere
    task automatic push_next(input int unsigned span,
                             input bit a_e, input bit b_e, input bit m_e, input bit s_e,
                             input bit a_l, input bit b_l);
        if ($urandom_range(0, 15) == 0)
            tick_now = $urandom;
        else
            tick_now = tick_now + $urandom_range(0, span);
        push_at(tick_now, a_e, b_e, m_e, s_e, a_l, b_l);
    endtask

    function automatic bit rare();
        return $urandom_range(0, 7) == 0;
    endfunction

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Mostly full detents (A falls, B may bounce, A rises), then button presses,
    // then raw noise with any flag mix
    task automatic gen_random(input int count, input int unsigned span);
        int added;
        int kind;
        int bounces;
        bit m_e;
        bit s_e;
        added = 0;
        while (added < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                bounces = $urandom_range(0, 2);
                push_next(span, 1'b1, rare(), rare(), rare(), 1'b0, coin());
                repeat (bounces)
                    push_next(span, 1'b0, 1'b1, rare(), rare(), coin(), coin());
                push_next(span, 1'b1, rare(), rare(), rare(), 1'b1, coin());
                added += bounces + 2;
            end else if (kind < 80) begin
                m_e = coin();
                s_e = m_e ? coin() : 1'b1;
                push_next(span, rare(), rare(), m_e, s_e, coin(), coin());
                added++;
            end else begin
                m_e = coin();
                s_e = coin();
                kind = $urandom_range(0, 3);
                push_next(span, kind[0], kind[1], m_e, s_e, coin(), coin());
                added++;
            end
        end
    endtask

    // Everything sent and every expected message back, then let the front settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_events.size() != 0 || evt.valid || expected_msgs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] glitch,
                              input logic [CFG_DATA_W-1:0] lockout);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_GLITCH;
        cfg_data <= glitch;
        @(posedge clk);
        cfg_idx  <= CFG_LOCKOUT;
        cfg_data <= lockout;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        evt.valid       = 1'b0;
        evt.event_tick  = '0;
        evt.enca_edge   = 1'b0;
        evt.encb_edge   = 1'b0;
        evt.mode_edge   = 1'b0;
        evt.select_edge = 1'b0;
        evt.enca_level  = 1'b0;
        evt.encb_level  = 1'b0;
        msg.ready       = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on reset register values
        jitter_on = 1'b0;
        push_at(32'd5,       0, 0, 0, 0, 1, 1);  // no flags: silent, no state change
        push_at(32'd10,      1, 0, 0, 0, 0, 1);  // A falls, B high latched
        push_at(32'd20,      1, 0, 0, 0, 1, 0);  // A rises too soon, B quiet: glitch
        push_at(32'd30,      0, 1, 0, 0, 0, 0);  // B moves
        push_at(32'd40,      1, 0, 0, 0, 1, 0);  // A rises soon but B moved: clockwise
        push_at(32'd200000,  1, 0, 0, 0, 0, 0);  // A falls, B low latched
        push_at(32'd400000,  1, 0, 0, 0, 1, 1);  // glitch time passed: counter-clockwise
        push_at(32'd2400000, 0, 0, 1, 0, 0, 0);  // mode exactly at lockout
        push_at(32'd2400001, 0, 0, 1, 0, 0, 0);  // mode bounce: rejected
        push_at(32'd2400000, 0, 0, 0, 1, 0, 0);  // select exactly at lockout
        push_at(32'hFFFF0000, 0, 0, 1, 0, 1, 0); // mode press late in the count
        push_at('1,          1, 1, 1, 1, 1, 1);  // every flag at max tick: three messages
        push_at(32'd0,       1, 0, 0, 0, 1, 0);  // A stamp + glitch wraps past zero
        push_at(32'd143999,  0, 1, 0, 0, 1, 1);
        push_at(32'd144000,  1, 1, 0, 0, 1, 1);  // A and B together: A uses old B stamp
        push_at(32'd144001,  1, 1, 0, 0, 0, 1);
        push_at(32'd144002,  1, 1, 0, 0, 1, 0);
        push_at(32'd100,     0, 0, 1, 1, 0, 0);  // both buttons, tick went backward
        wait_drained();

        // Small thresholds with ticks stepping across them
        write_regs(32'd50, 32'd120);
        jitter_on = 1'b1;
        gen_random(100, 200);
        wait_drained();

        // Zero thresholds: everything in order passes
        write_regs('0, '0);
        gen_random(60, 100);
        wait_drained();

        // Receiver holds off while the sender bursts two-message requests:
        // job queue fills and input ready drops
        jitter_on = 1'b0;
        hold_arm  = 1'b1;
        repeat (20) begin
            tick_now = tick_now + $urandom_range(1, 50);
            push_at(tick_now, 0, coin(), 1, 1, coin(), coin());
        end
        wait_drained();

        // Maximum thresholds: sums wrap to stamp - 1
        write_regs('1, '1);
        jitter_on = 1'b1;
        gen_random(70, 1 << 20);
        wait_drained();

        // Random small thresholds, no idling on either side
        write_regs($urandom_range(0, 300), $urandom_range(0, 300));
        jitter_on = 1'b0;
        gen_random(70, 400);
        wait_drained();

        // Back to reset values with realistic spacing
        write_regs(GLITCH_RESET, LOCKOUT_RESET);
        jitter_on = 1'b1;
        gen_random(80, 3000000);
        wait_drained();

        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("** encoder_button_event_qualifier: PASSED **");
        else
            $display("** encoder_button_event_qualifier: FAILED **");
        $finish;
    end

endmodule
